// ===== rtl/osva_pkg.sv =====
// ----------------------------------------------------------------------------
// osva_pkg: shared types and constants of the voice allocator
// Opcodes, fixed field widths, parameter defaults and the command
// struct passed from the sequencer to the voice file.
// ----------------------------------------------------------------------------
`default_nettype none

package osva_pkg;

    localparam int DEF_NUM_VOICES = 8;
    localparam int DEF_STAMP_BITS = 32;

    localparam int OP_W   = 2;
    localparam int NOTE_W = 7;
    localparam int VEL_W  = 7;
    localparam int DV_W   = 3;
    localparam int VIDX_W = 3;
    localparam int MASK_W = 8;

    typedef enum logic [OP_W-1:0] {
        OP_NOTE_ON    = 2'd0,
        OP_NOTE_OFF   = 2'd1,
        OP_VOICE_DONE = 2'd2
    } t_opcode;

    // Control from sequencer to voice file
    typedef struct packed {
        logic rd_en;   // read note, stamp and busy at the scan address
        logic wr_en;   // start a voice: write note and stamp, set busy
        logic clr_en;  // free a voice
    } t_vf_cmd;

endpackage : osva_pkg

`default_nettype wire

// ===== rtl/oldest_steal_voice_allocator.sv =====
// ----------------------------------------------------------------------------
// oldest_steal_voice_allocator: polyphonic voice allocator, oldest stealing
// Sequencer that scans the voice file one voice per cycle through a
// shared stamp compare and note match unit.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. A note on or a
// note off walks all NUM_VOICES voices, one per cycle through the voice
// file read port and the stamp comparator, then passes the commit state
// before its result; a voice-done or an unused opcode is answered from
// idle with no scan. Each command gives exactly one result, shown for
// one cycle with o_valid; the receiver cannot stall it, so it must take
// every result in the cycle it appears. busy stays high from the cycle
// after a note on or note off transfer until its result shows.
// A note on takes the lowest free voice, else the voice with the smallest
// start stamp (lowest index on ties) with o_voice_stolen set. Stamps wrap
// at STAMP_BITS and compare as plain unsigned values.
// ----------------------------------------------------------------------------
`default_nettype none

module oldest_steal_voice_allocator #(
    parameter int NUM_VOICES = osva_pkg::DEF_NUM_VOICES,
    parameter int STAMP_BITS = osva_pkg::DEF_STAMP_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [osva_pkg::OP_W-1:0]     i_opcode,
    input  wire logic [osva_pkg::NOTE_W-1:0]   i_note,
    input  wire logic [osva_pkg::VEL_W-1:0]    i_velocity,
    input  wire logic [osva_pkg::DV_W-1:0]     i_done_voice,
    output logic                               o_valid,
    output logic [osva_pkg::VIDX_W-1:0]        o_voice_index,
    output logic                               o_voice_started,
    output logic                               o_voice_stolen,
    output logic [osva_pkg::NOTE_W-1:0]        o_start_note,
    output logic [osva_pkg::VEL_W-1:0]         o_start_velocity,
    output logic [osva_pkg::MASK_W-1:0]        o_release_mask
);
    import osva_pkg::*;

    localparam int IDX_W = $clog2(NUM_VOICES);
    localparam int CNT_W = $clog2(NUM_VOICES + 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(NUM_VOICES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_VOICES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } t_state;

    t_state                r_state,      n_state;
    logic [OP_W-1:0]       r_op,         n_op;
    logic [NOTE_W-1:0]     r_note,       n_note;
    logic [VEL_W-1:0]      r_vel,        n_vel;
    logic [CNT_W-1:0]      r_rd_cnt,     n_rd_cnt;
    logic                  r_cmp_vld,    n_cmp_vld;
    logic [IDX_W-1:0]      r_cmp_idx,    n_cmp_idx;
    logic                  r_free_found, n_free_found;
    logic [IDX_W-1:0]      r_free_idx,   n_free_idx;
    logic [IDX_W-1:0]      r_best_idx,   n_best_idx;
    logic [STAMP_BITS-1:0] r_best_stamp, n_best_stamp;
    logic [MASK_W-1:0]     r_mask,       n_mask;
    logic [STAMP_BITS-1:0] r_stamp_ctr,  n_stamp_ctr;

    logic                  r_valid,      n_valid;
    logic [VIDX_W-1:0]     r_vidx,       n_vidx;
    logic                  r_started,    n_started;
    logic                  r_stolen,     n_stolen;
    logic [NOTE_W-1:0]     r_snote,      n_snote;
    logic [VEL_W-1:0]      r_svel,       n_svel;
    logic [MASK_W-1:0]     r_rmask,      n_rmask;

    t_vf_cmd               vf_cmd;
    logic [IDX_W-1:0]      chosen_idx;
    logic [IDX_W-1:0]      clr_addr;
    logic                  rd_busy;
    logic [NOTE_W-1:0]     rd_note;
    logic [STAMP_BITS-1:0] rd_stamp;

    osva_voice_file #(
        .NUM_VOICES (NUM_VOICES),
        .STAMP_BITS (STAMP_BITS)
    ) u_voice_file (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (vf_cmd),
        .i_rd_addr  (r_rd_cnt[IDX_W-1:0]),
        .i_wr_addr  (chosen_idx),
        .i_wr_note  (r_note),
        .i_wr_stamp (r_stamp_ctr),
        .i_clr_addr (clr_addr),
        .o_rd_busy  (rd_busy),
        .o_rd_note  (rd_note),
        .o_rd_stamp (rd_stamp)
    );

    assign busy       = (r_state != S_IDLE);
    assign chosen_idx = r_free_found ? r_free_idx : r_best_idx;
    assign clr_addr   = IDX_W'(i_done_voice);

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_note       = r_note;
        n_vel        = r_vel;
        n_rd_cnt     = r_rd_cnt;
        n_cmp_vld    = 1'b0;
        n_cmp_idx    = r_cmp_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_best_idx   = r_best_idx;
        n_best_stamp = r_best_stamp;
        n_mask       = r_mask;
        n_stamp_ctr  = r_stamp_ctr;
        n_valid      = 1'b0;
        n_vidx       = r_vidx;
        n_started    = r_started;
        n_stolen     = r_stolen;
        n_snote      = r_snote;
        n_svel       = r_svel;
        n_rmask      = r_rmask;
        vf_cmd       = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op   = i_opcode;
                    n_note = i_note;
                    n_vel  = i_velocity;
                    case (i_opcode)
                        OP_NOTE_ON, OP_NOTE_OFF: begin
                            n_state      = S_SCAN;
                            n_rd_cnt     = '0;
                            n_free_found = 1'b0;
                            n_mask       = '0;
                        end
                        OP_VOICE_DONE: begin
                            vf_cmd.clr_en = (int'(i_done_voice) < NUM_VOICES);
                            n_valid       = 1'b1;
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                    // Everything but a started voice or a note-off release mask reports all-zero fields
                    n_vidx    = '0;
                    n_started = 1'b0;
                    n_stolen  = 1'b0;
                    n_snote   = '0;
                    n_svel    = '0;
                    n_rmask   = '0;
                end
            end

            S_SCAN: begin
                // Issue the next read; data shows at the compare stage next cycle
                if (r_rd_cnt < CNT_END) begin
                    vf_cmd.rd_en = 1'b1;
                    n_rd_cnt     = r_rd_cnt + 1'b1;
                    n_cmp_vld    = 1'b1;
                    n_cmp_idx    = r_rd_cnt[IDX_W-1:0];
                end
                if (r_cmp_vld) begin
                    if (r_op == OP_NOTE_ON) begin
                        if (!rd_busy && !r_free_found) begin
                            n_free_found = 1'b1;
                            n_free_idx   = r_cmp_idx;
                        end
                        // Strict less-than keeps the lowest index on ties
                        if (r_cmp_idx == '0 || rd_stamp < r_best_stamp) begin
                            n_best_idx   = r_cmp_idx;
                            n_best_stamp = rd_stamp;
                        end
                    end else begin
                        // Voices past the mask width shift out and drop
                        if (rd_busy && rd_note == r_note) begin
                            n_mask = r_mask | (MASK_W'(1) << r_cmp_idx);
                        end
                    end
                    if (r_cmp_idx == LAST_IDX) begin
                        n_state = S_COMMIT;
                    end
                end
            end

            S_COMMIT: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
                if (r_op == OP_NOTE_ON) begin
                    vf_cmd.wr_en = 1'b1;
                    n_stamp_ctr  = r_stamp_ctr + 1'b1;
                    n_vidx       = VIDX_W'(chosen_idx);
                    n_started    = 1'b1;
                    n_stolen     = !r_free_found;
                    n_snote      = r_note;
                    n_svel       = r_vel;
                end else begin
                    n_rmask = r_mask;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_stamp_ctr <= '0;
        end else begin
            r_state      <= n_state;
            r_op         <= n_op;
            r_note       <= n_note;
            r_vel        <= n_vel;
            r_rd_cnt     <= n_rd_cnt;
            r_cmp_vld    <= n_cmp_vld;
            r_cmp_idx    <= n_cmp_idx;
            r_free_found <= n_free_found;
            r_free_idx   <= n_free_idx;
            r_best_idx   <= n_best_idx;
            r_best_stamp <= n_best_stamp;
            r_mask       <= n_mask;
            r_stamp_ctr  <= n_stamp_ctr;
            r_valid      <= n_valid;
            r_vidx       <= n_vidx;
            r_started    <= n_started;
            r_stolen     <= n_stolen;
            r_snote      <= n_snote;
            r_svel       <= n_svel;
            r_rmask      <= n_rmask;
        end
    end

    assign o_valid          = r_valid;
    assign o_voice_index    = r_vidx;
    assign o_voice_started  = r_started;
    assign o_voice_stolen   = r_stolen;
    assign o_start_note     = r_snote;
    assign o_start_velocity = r_svel;
    assign o_release_mask   = r_rmask;

endmodule : oldest_steal_voice_allocator

`default_nettype wire

// ===== rtl/osva_voice_file.sv =====
// ----------------------------------------------------------------------------
// osva_voice_file: per-voice state storage
// Busy flags in flip-flops cleared by reset; note and start stamp in a
// memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module osva_voice_file #(
    parameter int NUM_VOICES = osva_pkg::DEF_NUM_VOICES,
    parameter int STAMP_BITS = osva_pkg::DEF_STAMP_BITS,
    localparam int IDX_W     = $clog2(NUM_VOICES)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire osva_pkg::t_vf_cmd         i_cmd,
    input  wire logic [IDX_W-1:0]          i_rd_addr,
    input  wire logic [IDX_W-1:0]          i_wr_addr,
    input  wire logic [osva_pkg::NOTE_W-1:0] i_wr_note,
    input  wire logic [STAMP_BITS-1:0]     i_wr_stamp,
    input  wire logic [IDX_W-1:0]          i_clr_addr,
    output logic                           o_rd_busy,
    output logic [osva_pkg::NOTE_W-1:0]    o_rd_note,
    output logic [STAMP_BITS-1:0]          o_rd_stamp
);
    import osva_pkg::*;

    logic [NUM_VOICES-1:0] r_busy;
    logic [NOTE_W-1:0]     r_note_mem  [NUM_VOICES];
    logic [STAMP_BITS-1:0] r_stamp_mem [NUM_VOICES];

    // Busy flags: a note on sets, a voice-done clears
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
        end else begin
            if (i_cmd.wr_en) begin
                r_busy[i_wr_addr] <= 1'b1;
            end
            if (i_cmd.clr_en) begin
                r_busy[i_clr_addr] <= 1'b0;
            end
        end
    end

    // Note and stamp only matter for busy voices: no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_note_mem[i_wr_addr]  <= i_wr_note;
            r_stamp_mem[i_wr_addr] <= i_wr_stamp;
        end
        if (i_cmd.rd_en) begin
            o_rd_busy  <= r_busy[i_rd_addr];
            o_rd_note  <= r_note_mem[i_rd_addr];
            o_rd_stamp <= r_stamp_mem[i_rd_addr];
        end
    end

endmodule : osva_voice_file

`default_nettype wire
